// File: rtl/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg: shared types and constants for the tone/noise sound generator
// Operation codes, register indexes, volume table and the channel snapshot
// passed from the generator core to the mixer.
// ----------------------------------------------------------------------------
package psg_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } psg_op_e;

  localparam logic [2:0]  REG_NOISE  = 3'd6;
  localparam logic [1:0]  RATE_TONE2 = 2'd3;
  localparam logic [15:0] NOISE_SEED = 16'h8000;
  localparam logic [3:0]  ATT_SILENT = 4'd15;

  // Channel state visible to the mixer after each transfer
  typedef struct packed {
    logic [3:0][3:0] atten;   // index 3 is noise
    logic            noise;
    logic [2:0]      square;
  } psg_snap_t;

  // Attenuation in 2 dB steps, 10^(-a/10) in Q1.15, code 15 is off
  function automatic logic [15:0] vol_q15(input logic [3:0] att);
    logic [15:0] v;
    case (att)
      4'd0:    v = 16'd32768;
      4'd1:    v = 16'd26029;
      4'd2:    v = 16'd20675;
      4'd3:    v = 16'd16423;
      4'd4:    v = 16'd13045;
      4'd5:    v = 16'd10362;
      4'd6:    v = 16'd8231;
      4'd7:    v = 16'd6538;
      4'd8:    v = 16'd5193;
      4'd9:    v = 16'd4125;
      4'd10:   v = 16'd3277;
      4'd11:   v = 16'd2603;
      4'd12:   v = 16'd2068;
      4'd13:   v = 16'd1642;
      4'd14:   v = 16'd1305;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Fixed noise reload values for rate codes 0..2
  function automatic logic [9:0] noise_rate(input logic [1:0] rate);
    logic [9:0] r;
    case (rate)
      2'd0:    r = 10'h010;
      2'd1:    r = 10'h020;
      2'd2:    r = 10'h040;
      default: r = 10'h010;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/psg_tone_noise_generator_top.sv
// ----------------------------------------------------------------------------
// psg_tone_noise_generator_top: three-tone, one-noise sound generator
// Usage:
//   Slave stream: tuser carries the operation (register write byte, master
//   clock tick, direct generator step), tdata carries the written byte.
//   Master stream: one transfer per input transfer with the mixed level
//   (Q1.15), the three tone square bits and the noise bit after that item.
//   Order: state updates at the accepting edge, and the result register then
//   loads from that state once it is empty or being drained, so a result is
//   offered from the result register after the generator state update.
//   Throughput: one transfer per cycle while the master side takes the
//   results; the generator state registers are the only loop.
//   Stall: while the result register is full and not taken, one more item
//   is accepted; its state snapshot then holds and tready drops; it
//   recovers in the same cycle the master side takes the result.
//   Reset: all tones silent (attenuation 15), LFSR seeded to 0x8000,
//   prescaler at CLOCK_DIVIDE, no pending or offered results.
// ----------------------------------------------------------------------------
module psg_tone_noise_generator_top import psg_pkg::*; #(
  parameter int CLOCK_DIVIDE = 16   // master ticks per generator step, 1..31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [15:0] mixed_level, [18:16] tone_bits,
                                        // [19] noise_bit, [23:20] zero
);

  psg_snap_t   snap;
  logic        accept;
  logic        out_en;
  logic        load;
  logic        pend_q, pend_d;
  logic        oval_q, oval_d;
  logic [15:0] level;
  logic [2:0]  tone;
  logic        noise;

  // Result register can load when empty or being drained this cycle.
  assign out_en = !oval_q || m_axis_tready_i;
  // State may advance only if the snapshot of the last item is moving on.
  assign s_axis_tready_o = !pend_q || out_en;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign load   = pend_q && out_en;

  always_comb begin
    pend_d = pend_q;
    oval_d = oval_q;
    if (load) pend_d = 1'b0;
    if (accept) pend_d = 1'b1;
    if (out_en) oval_d = pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      oval_q <= oval_d;
    end
  end

  psg_gen #(
    .CLOCK_DIVIDE(CLOCK_DIVIDE)
  ) u_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .op_i    (s_axis_tuser_i),
    .data_i  (s_axis_tdata_i),
    .snap_o  (snap)
  );

  psg_mix u_mix (
    .clk_i  (clk_i),
    .load_i (load),
    .snap_i (snap),
    .level_o(level),
    .tone_o (tone),
    .noise_o(noise)
  );

  assign m_axis_tvalid_o = oval_q;
  assign m_axis_tdata_o  = {4'b0000, noise, tone, level};

endmodule

// File: rtl/psg_gen.sv
// ----------------------------------------------------------------------------
// psg_gen: register file, prescaler, tone counters and noise LFSR
// Updates all generator state in the cycle an item is accepted.
// ----------------------------------------------------------------------------
module psg_gen import psg_pkg::*; #(
  parameter int CLOCK_DIVIDE = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  logic [1:0] op_i,
  input  logic [7:0] data_i,
  output psg_snap_t snap_o
);

  logic [9:0]  period_q [3];
  logic [9:0]  period_d [3];
  logic [9:0]  count_q  [3];
  logic [9:0]  count_d  [3];
  logic [2:0]  square_q, square_d;
  logic [3:0][3:0] atten_q, atten_d;
  logic [2:0]  mode_q, mode_d;
  logic [9:0]  ncount_q, ncount_d;
  logic        half_q, half_d;
  logic [15:0] lfsr_q, lfsr_d;
  logic        level_q, level_d;
  logic [2:0]  latch_q, latch_d;
  logic [4:0]  presc_q, presc_d;

  always_comb begin
    logic       step;
    logic [2:0] reg_sel;
    logic [4:0] presc_dec;
    logic [9:0] cnt_dec;
    logic [9:0] ncnt_dec;
    logic       fb;

    period_d = period_q;
    count_d  = count_q;
    square_d = square_q;
    atten_d  = atten_q;
    mode_d   = mode_q;
    ncount_d = ncount_q;
    half_d   = half_q;
    lfsr_d   = lfsr_q;
    level_d  = level_q;
    latch_d  = latch_q;
    presc_d  = presc_q;
    step     = 1'b0;
    reg_sel  = data_i[7] ? data_i[6:4] : latch_q;
    presc_dec = presc_q - 5'd1;
    cnt_dec  = '0;
    ncnt_dec = '0;
    fb       = 1'b0;

    if (accept_i) begin
      case (psg_op_e'(op_i))
        OP_WRITE: begin
          latch_d = reg_sel;
          if (reg_sel[0]) begin
            atten_d[reg_sel[2:1]] = data_i[3:0];
          end else if (reg_sel == REG_NOISE) begin
            mode_d = data_i[2:0];
            lfsr_d = NOISE_SEED;
          end else begin
            for (int i = 0; i < 3; i++) begin
              if (reg_sel[2:1] == 2'(i)) begin
                if (data_i[7]) begin
                  period_d[i] = {period_q[i][9:4], data_i[3:0]};
                end else begin
                  period_d[i] = {data_i[5:0], period_q[i][3:0]};
                end
              end
            end
          end
        end
        OP_TICK: begin
          presc_d = presc_dec;
          if (presc_dec == '0) begin
            presc_d = 5'(CLOCK_DIVIDE);
            step    = 1'b1;
          end
        end
        OP_STEP: step = 1'b1;
        default: ;
      endcase
    end

    if (step) begin
      for (int i = 0; i < 3; i++) begin
        cnt_dec = count_q[i] - 10'd1;
        count_d[i] = cnt_dec;
        if (cnt_dec == '0) begin
          count_d[i]  = (period_q[i] != '0) ? period_q[i] : 10'd1;
          square_d[i] = ~square_q[i];
        end
      end

      ncnt_dec = (ncount_q != '0) ? ncount_q - 10'd1 : ncount_q;
      ncount_d = ncnt_dec;
      if (ncnt_dec == '0) begin
        ncount_d = (mode_q[1:0] == RATE_TONE2) ? period_q[2] : noise_rate(mode_q[1:0]);
        half_d   = ~half_q;
        if (!half_q) begin
          // white noise taps bits 0 and 3, periodic recirculates bit 0
          fb      = mode_q[2] ? (lfsr_q[0] ^ lfsr_q[3]) : lfsr_q[0];
          level_d = lfsr_q[0];
          lfsr_d  = {fb, lfsr_q[15:1]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        period_q[i] <= '0;
        count_q[i]  <= 10'd1;
      end
      square_q <= '0;
      atten_q  <= {4{ATT_SILENT}};
      mode_q   <= '0;
      ncount_q <= '0;
      half_q   <= 1'b0;
      lfsr_q   <= NOISE_SEED;
      level_q  <= 1'b0;
      latch_q  <= '0;
      presc_q  <= 5'(CLOCK_DIVIDE);
    end else begin
      period_q <= period_d;
      count_q  <= count_d;
      square_q <= square_d;
      atten_q  <= atten_d;
      mode_q   <= mode_d;
      ncount_q <= ncount_d;
      half_q   <= half_d;
      lfsr_q   <= lfsr_d;
      level_q  <= level_d;
      latch_q  <= latch_d;
      presc_q  <= presc_d;
    end
  end

  assign snap_o.atten  = atten_q;
  assign snap_o.noise  = level_q;
  assign snap_o.square = square_q;

endmodule

// File: rtl/psg_mix.sv
// ----------------------------------------------------------------------------
// psg_mix: volume lookup and mixer with result register
// Sums the volumes of high channels, divides by four with rounding.
// ----------------------------------------------------------------------------
module psg_mix import psg_pkg::*; (
  input  logic       clk_i,
  input  logic       load_i,
  input  psg_snap_t  snap_i,
  output logic [15:0] level_o,
  output logic [2:0]  tone_o,
  output logic        noise_o
);

  logic [17:0] sum;
  logic [17:0] rnd;
  logic [15:0] level_d, level_q;
  logic [2:0]  tone_q;
  logic        noise_q;

  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      if (snap_i.square[i]) sum = sum + 18'(vol_q15(snap_i.atten[i]));
    end
    if (snap_i.noise) sum = sum + 18'(vol_q15(snap_i.atten[3]));
    rnd     = sum + 18'd2;
    level_d = rnd[17:2];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      level_q <= level_d;
      tone_q  <= snap_i.square;
      noise_q <= snap_i.noise;
    end
  end

  assign level_o = level_q;
  assign tone_o  = tone_q;
  assign noise_o = noise_q;

endmodule

// File: dv/psg_tone_noise_generator_top_tb.sv
// ----------------------------------------------------------------------------
// psg_tone_noise_generator_top_tb: self-checking bench for the sound generator
// A stream driver sends register write bytes, master ticks, direct steps and
// undefined operations, and a built-in model of the tone, noise and mixer
// logic predicts the result of every transfer. A monitor checks every result
// transfer field by field against the oldest prediction. Both sides idle at
// random, and the sender drains the pipe at least once.
// ----------------------------------------------------------------------------
module psg_tone_noise_generator_top_tb;
  import psg_pkg::*;

  localparam int DIV        = 16;    // master ticks per generator step
  localparam int N_ITEMS    = 750;   // random items after the directed part
  localparam int IDLE_LIMIT = 4000;  // cycles with no transfer before giving up
  localparam int TAIL       = 8;     // settle cycles after the last result

  // One stimulus item; drain makes the sender wait for an empty pipe first
  typedef struct {
    psg_op_e    op;
    logic [7:0] data;
    bit         drain;
  } psg_cmd_t;

  // Result fields in tdata order, lowest bits last
  typedef struct packed {
    logic        noise;
    logic [2:0]  tones;
    logic [15:0] level;
  } psg_mix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  psg_op_e     s_axis_tuser_i = OP_NONE;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;

  psg_cmd_t cmd_q[$];
  psg_mix_t mix_q[$];
  int       err_count = 0;
  int       idle_cycles = 0;
  int       src_gap = 0;
  int       snk_stall = 0;
  bit       src_burst = 1'b0;
  bit       snk_burst = 1'b0;

  // Model state of the generator
  logic [9:0]  tone_per [3];
  logic [9:0]  tone_cnt [3];
  logic [2:0]  sq_lvl;
  logic [3:0]  att [4];
  logic [2:0]  nz_mode;
  logic [9:0]  nz_cnt;
  logic        nz_half;
  logic [15:0] lfsr;
  logic        nz_lvl;
  logic [2:0]  latch_reg;
  logic [4:0]  presc;
  logic [15:0] vol_lut [16];

  psg_tone_noise_generator_top #(
    .CLOCK_DIVIDE(DIV)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),   // [7:0] data_byte
    .s_axis_tuser_i (s_axis_tuser_i),   // [1:0] operation
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)    // [15:0] level, [18:16] tones, [19] noise
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Generator model
  // --------------------------------------------------------------------------
  task automatic model_reset();
    for (int i = 0; i < 3; i++) begin
      tone_per[i] = '0;
      tone_cnt[i] = 10'd1;
    end
    for (int a = 0; a < 15; a++)
      vol_lut[a] = 16'($rtoi(32768.0 * $pow(10.0, -0.1 * a) + 0.5));
    vol_lut[15] = '0;
    for (int i = 0; i < 4; i++) att[i] = ATT_SILENT;
    sq_lvl    = '0;
    nz_mode   = '0;
    nz_cnt    = '0;
    nz_half   = 1'b0;
    lfsr      = NOISE_SEED;
    nz_lvl    = 1'b0;
    latch_reg = '0;
    presc     = 5'(DIV);
  endtask

  // Low nibble from a latch byte, or the data byte on the latched register
  task automatic write_reg(input logic [2:0] r, input logic [7:0] b, input bit is_latch);
    int ch;
    ch = r[2:1];
    if (r[0]) begin
      att[ch] = b[3:0];
    end else if (r == REG_NOISE) begin
      nz_mode = b[2:0];
      lfsr    = NOISE_SEED;
    end else if (is_latch) begin
      tone_per[ch][3:0] = b[3:0];
    end else begin
      tone_per[ch][9:4] = b[5:0];
    end
  endtask

  task automatic gen_step();
    logic fb;
    for (int i = 0; i < 3; i++) begin
      tone_cnt[i] = tone_cnt[i] - 10'd1;
      if (tone_cnt[i] == '0) begin
        // zero period reloads as one
        tone_cnt[i] = (tone_per[i] != '0) ? tone_per[i] : 10'd1;
        sq_lvl[i]   = ~sq_lvl[i];
      end
    end
    if (nz_cnt != '0) nz_cnt = nz_cnt - 10'd1;
    if (nz_cnt == '0) begin
      case (nz_mode[1:0])
        2'd0:       nz_cnt = 10'h010;
        2'd1:       nz_cnt = 10'h020;
        2'd2:       nz_cnt = 10'h040;
        RATE_TONE2: nz_cnt = tone_per[2];   // zero here clocks every step
      endcase
      nz_half = ~nz_half;
      if (nz_half) begin
        nz_lvl = lfsr[0];
        fb     = nz_mode[2] ? (lfsr[0] ^ lfsr[3]) : lfsr[0];
        lfsr   = {fb, lfsr[15:1]};
      end
    end
  endtask

  // Apply one accepted item and queue the mix it must produce
  task automatic predict_mix(input psg_op_e op, input logic [7:0] b);
    logic [17:0] sum;
    psg_mix_t    m;
    case (op)
      OP_WRITE: begin
        if (b[7]) begin
          latch_reg = b[6:4];
          write_reg(latch_reg, b, 1'b1);
        end else begin
          write_reg(latch_reg, b, 1'b0);
        end
      end
      OP_TICK: begin
        presc = presc - 5'd1;
        if (presc == '0) begin
          presc = 5'(DIV);
          gen_step();
        end
      end
      OP_STEP: gen_step();
      default: ;   // undefined op leaves the state alone
    endcase
    sum = '0;
    for (int i = 0; i < 3; i++)
      if (sq_lvl[i]) sum = sum + vol_lut[att[i]];
    if (nz_lvl) sum = sum + vol_lut[att[3]];
    sum     = sum + 18'd2;
    m.level = sum[17:2];
    m.tones = sq_lvl;
    m.noise = nz_lvl;
    mix_q.push_back(m);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_cmd(input psg_op_e op, input logic [7:0] b, input bit drain = 1'b0);
    psg_cmd_t c;
    c.op    = op;
    c.data  = b;
    c.drain = drain;
    cmd_q.push_back(c);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents the queue head, predicts on each accepted transfer
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_proc
    bit fired;
    fired = s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni) begin
      if (fired) begin
        predict_mix(s_axis_tuser_i, s_axis_tdata_i);
        if ($urandom_range(0, 59) == 0) src_burst = ~src_burst;
        src_gap = src_burst ? 0 : pick_gap();
      end
      if (!s_axis_tvalid_i || fired) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && mix_q.size() != 0)) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= cmd_q[0].op;
          s_axis_tdata_i  <= cmd_q[0].data;
          void'(cmd_q.pop_front());
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks result transfers, throttles tready
  // --------------------------------------------------------------------------
  task automatic report_field(input string name, input int want, input int got);
    err_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  always @(posedge clk_i) begin : check_proc
    psg_mix_t want;
    psg_mix_t got;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = psg_mix_t'(m_axis_tdata_o[19:0]);
        if (mix_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata_o);
        end else begin
          want = mix_q.pop_front();
          if (got.level !== want.level) report_field("mixed_level", want.level, got.level);
          if (got.tones !== want.tones) report_field("tone_bits", want.tones, got.tones);
          if (got.noise !== want.noise) report_field("noise_bit", want.noise, got.noise);
        end
        if ($urandom_range(0, 59) == 0) snk_burst = ~snk_burst;
      end
      if (snk_stall == 0 && !snk_burst && $urandom_range(0, 3) == 0) snk_stall = pick_gap();
      if (snk_stall > 0) begin
        snk_stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  initial begin
    int       n;
    int       r;
    int       ch;
    int       run;
    psg_op_e  op;

    model_reset();

    // Directed: reset output, undefined op, full volume on every channel,
    // white noise on tone 2 rate with a zero period, tone period extremes
    add_cmd(OP_STEP,  8'h00);
    add_cmd(OP_NONE,  8'hFF);
    add_cmd(OP_WRITE, 8'h90);   // tone 0 attenuation 0
    add_cmd(OP_WRITE, 8'hB0);   // tone 1 attenuation 0
    add_cmd(OP_WRITE, 8'hD0);   // tone 2 attenuation 0
    add_cmd(OP_WRITE, 8'hF0);   // noise attenuation 0
    add_cmd(OP_WRITE, 8'hE7);   // white noise, clocked by tone 2 (period 0)
    repeat (3) add_cmd(OP_STEP, 8'hFF);   // data byte ignored
    add_cmd(OP_WRITE, 8'h8F);   // tone 0 low nibble
    add_cmd(OP_WRITE, 8'h3F);   // tone 0 high bits: period 0x3FF
    add_cmd(OP_WRITE, 8'hA1);   // tone 1 period 1
    add_cmd(OP_WRITE, 8'hC0);   // tone 2 low nibble 0
    add_cmd(OP_WRITE, 8'h00);   // tone 2 high bits 0: zero period
    add_cmd(OP_WRITE, 8'hD7);   // tone 2 attenuation via latch
    add_cmd(OP_WRITE, 8'h0E);   // data byte on attenuation: 14
    add_cmd(OP_WRITE, 8'hE0);   // periodic noise, rate 16, reseed
    add_cmd(OP_WRITE, 8'h05);   // data byte on noise control: white, rate 32
    repeat (4) add_cmd(OP_TICK, 8'hA5);
    add_cmd(OP_STEP, 8'h00, 1'b1);   // drain before the random part

    // Random: mostly well-formed latch/data pairs and runs of steps or ticks
    n = 0;
    while (n < N_ITEMS) begin
      r  = $urandom_range(0, 99);
      ch = $urandom_range(0, 2);
      if (r < 30) begin
        add_cmd(OP_WRITE, {1'b1, 2'(ch), 1'b0, 4'($urandom)}, (n % 250) == 249);
        n++;
        if ($urandom_range(0, 9) < 7) begin
          // short periods keep the square waves and tone-2 noise busy
          add_cmd(OP_WRITE, {2'($urandom),
                             ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 3))
                                                         : 6'($urandom)});
          n++;
        end
      end else if (r < 45) begin
        add_cmd(OP_WRITE, {1'b1, 2'($urandom_range(0, 3)), 1'b1, 4'($urandom)});
        n++;
        if ($urandom_range(0, 3) == 0) begin
          add_cmd(OP_WRITE, {1'b0, 7'($urandom)});
          n++;
        end
      end else if (r < 50) begin
        add_cmd(OP_WRITE, {4'hE, 4'($urandom)});
        n++;
        if ($urandom_range(0, 3) == 0) begin
          add_cmd(OP_WRITE, {1'b0, 7'($urandom)});
          n++;
        end
      end else if (r < 55) begin
        op = psg_op_e'($urandom_range(0, 3));
        add_cmd(op, 8'($urandom));
        n++;
      end else if (r < 80) begin
        run = $urandom_range(1, 20);
        repeat (run) add_cmd(OP_STEP, 8'($urandom));
        n += run;
      end else if (r < 98) begin
        run = $urandom_range(1, 40);
        repeat (run) add_cmd(OP_TICK, 8'($urandom));
        n += run;
      end else begin
        add_cmd(OP_NONE, 8'($urandom));
        n++;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (mix_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    if (err_count == 0 && mix_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/psg_pkg.sv
rtl/psg_gen.sv
rtl/psg_mix.sv
rtl/psg_tone_noise_generator_top.sv
dv/psg_tone_noise_generator_top_tb.sv
